// ===== sv/wtsp_pkg.sv =====
// ============================================================================
// wtsp_pkg
// Shared widths, register indexes and types of the world-to-screen projection.
// ============================================================================
`default_nettype none

package wtsp_pkg;

   localparam int QH_W  = 16;   // one quaternion component, Q2.14
   localparam int PQ_W  = 32;   // product of two quaternion components
   localparam int EW    = 35;   // matrix entry before rounding, Q7.28
   localparam int MW    = 22;   // matrix entry after rounding, Q16
   localparam int RW    = 33;   // point minus camera position
   localparam int PW    = 55;   // matrix entry times offset
   localparam int SW    = 57;   // sum of three such products
   localparam int CW    = 41;   // camera-space coordinate, Q25.16
   localparam int DW    = 40;   // depth and coordinate magnitude
   localparam int HW    = 20;   // half of a magnitude for the split multiply
   localparam int FW    = 31;   // focal factor and near distance
   localparam int PPW   = 51;   // partial product of half magnitude and focal factor
   localparam int NW    = 72;   // dividend
   localparam int QW    = 41;   // quotient bits
   localparam int NDW   = 42;   // signed normalised coordinate
   localparam int TW    = 43;   // one plus or minus normalised coordinate
   localparam int VW    = 16;   // viewport dimension
   localparam int PXW   = 60;   // pixel product
   localparam int OW    = 32;   // output coordinate
   localparam int DIV_LAT = QW + 1;

   localparam logic [QW-1:0]          NDC_CAP  = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [EW-1:0]   ONE_Q28  = EW'(64'sd268435456);
   localparam logic signed [TW-1:0]   ONE_Q16  = TW'(64'sd65536);

   localparam logic [2:0] REG_CAM_X  = 3'd0;
   localparam logic [2:0] REG_CAM_Y  = 3'd1;
   localparam logic [2:0] REG_CAM_Z  = 3'd2;
   localparam logic [2:0] REG_QUAT   = 3'd3;
   localparam logic [2:0] REG_NEAR   = 3'd4;
   localparam logic [2:0] REG_FOCAL_X = 3'd5;
   localparam logic [2:0] REG_FOCAL_Y = 3'd6;
   localparam logic [2:0] REG_VIEWPORT = 3'd7;

   typedef struct packed {
      logic [31:0]          cam_x;
      logic [31:0]          cam_y;
      logic [31:0]          cam_z;
      logic [FW-1:0]        near;
      logic [FW-1:0]        fx;
      logic [FW-1:0]        fy;
      logic [VW-1:0]        vw;
      logic [VW-1:0]        vh;
      logic [8:0][MW-1:0]   mat;
   } cfg_type;

   typedef struct packed {
      logic [RW-1:0] rx;
      logic [RW-1:0] ry;
      logic [RW-1:0] rz;
   } point_type;

   typedef struct packed {
      logic vis;
      logic sx;
      logic sy;
   } side_type;

endpackage

`default_nettype wire

// ===== sv/wtsp_csr.sv =====
// ============================================================================
// wtsp_csr
// Configuration registers and the rotation matrix derived from the quaternion.
// ============================================================================
`default_nettype none

module wtsp_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata,
   output wtsp_pkg::cfg_type       cfg
);
   import wtsp_pkg::*;

   logic [31:0]    cam_x_ff, cam_y_ff, cam_z_ff;
   logic [63:0]    quat_ff;
   logic [FW-1:0]  near_ff, fx_ff, fy_ff;
   logic [31:0]    view_ff;

   logic signed [PQ_W-1:0] prod_ff [0:8];
   logic signed [PQ_W-1:0] prod_in [0:8];
   logic [8:0][MW-1:0]     mat_ff;
   logic [8:0][MW-1:0]     mat_in;
   logic signed [QH_W-1:0] qw, qa, qb, qc;
   logic signed [EW-1:0]   ent [0:8];
   logic signed [EW-1:0]   rnd [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         quat_ff  <= 64'd16384;
         near_ff  <= FW'(6554);
         fx_ff    <= FW'(65536);
         fy_ff    <= FW'(65536);
         view_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CAM_X:    cam_x_ff <= csr_wdata[31:0];
            REG_CAM_Y:    cam_y_ff <= csr_wdata[31:0];
            REG_CAM_Z:    cam_z_ff <= csr_wdata[31:0];
            REG_QUAT:     quat_ff  <= csr_wdata;
            REG_NEAR:     near_ff  <= csr_wdata[FW-1:0];
            REG_FOCAL_X:  fx_ff    <= csr_wdata[FW-1:0];
            REG_FOCAL_Y:  fy_ff    <= csr_wdata[FW-1:0];
            REG_VIEWPORT: view_ff  <= csr_wdata[31:0];
            default:      view_ff  <= view_ff;
         endcase
      end
   end

   always_comb begin
      qw = $signed(quat_ff[15:0]);
      qa = $signed(quat_ff[31:16]);
      qb = $signed(quat_ff[47:32]);
      qc = $signed(quat_ff[63:48]);
      prod_in[0] = qa * qa;
      prod_in[1] = qb * qb;
      prod_in[2] = qc * qc;
      prod_in[3] = qa * qb;
      prod_in[4] = qw * qc;
      prod_in[5] = qa * qc;
      prod_in[6] = qw * qb;
      prod_in[7] = qb * qc;
      prod_in[8] = qw * qa;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      mat_ff <= mat_in;
   end

   always_comb begin
      ent[0] = ONE_Q28 - ((EW'(prod_ff[1]) + EW'(prod_ff[2])) <<< 1);
      ent[1] = (EW'(prod_ff[3]) - EW'(prod_ff[4])) <<< 1;
      ent[2] = (EW'(prod_ff[5]) + EW'(prod_ff[6])) <<< 1;
      ent[3] = (EW'(prod_ff[3]) + EW'(prod_ff[4])) <<< 1;
      ent[4] = ONE_Q28 - ((EW'(prod_ff[0]) + EW'(prod_ff[2])) <<< 1);
      ent[5] = (EW'(prod_ff[7]) - EW'(prod_ff[8])) <<< 1;
      ent[6] = (EW'(prod_ff[5]) - EW'(prod_ff[6])) <<< 1;
      ent[7] = (EW'(prod_ff[7]) + EW'(prod_ff[8])) <<< 1;
      ent[8] = ONE_Q28 - ((EW'(prod_ff[0]) + EW'(prod_ff[1])) <<< 1);
      for (int i = 0; i < 9; i++) begin
         rnd[i]    = ent[i] + EW'(2048);
         mat_in[i] = rnd[i][MW+11:12];
      end
   end

   always_comb begin
      cfg.cam_x = cam_x_ff;
      cfg.cam_y = cam_y_ff;
      cfg.cam_z = cam_z_ff;
      cfg.near  = near_ff;
      cfg.fx    = fx_ff;
      cfg.fy    = fy_ff;
      cfg.vw    = view_ff[15:0];
      cfg.vh    = view_ff[31:16];
      cfg.mat   = mat_ff;
   end

endmodule

`default_nettype wire

// ===== sv/wtsp_front.sv =====
// ============================================================================
// wtsp_front
// Request intake: removes the camera offset and queues the result for the
// back end.
// ============================================================================
`default_nettype none

module wtsp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [31:0]          req_point_x,
   input  wire logic [31:0]          req_point_y,
   input  wire logic [31:0]          req_point_z,
   input  wire wtsp_pkg::cfg_type    cfg,
   input  wire logic                 pop,
   output logic                      q_valid,
   output wtsp_pkg::point_type       q_data
);
   import wtsp_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = 2;

   logic       f_v_ff, f_v_in;
   point_type  f_pt_ff, f_pt_in;
   point_type  mem_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic       full, push, accept;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign push      = f_v_ff && !full;
   assign req_stall = f_v_ff && full;
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      f_pt_in.rx = RW'($signed(req_point_x)) - RW'($signed(cfg.cam_x));
      f_pt_in.ry = RW'($signed(req_point_y)) - RW'($signed(cfg.cam_y));
      f_pt_in.rz = RW'($signed(req_point_z)) - RW'($signed(cfg.cam_z));
      if (accept) begin
         f_v_in = 1'b1;
      end else if (push) begin
         f_v_in = 1'b0;
      end else begin
         f_v_in = f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         f_v_ff <= f_v_in;
         if (push) begin
            wr_ff <= wr_ff + AW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + AW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + (AW+1)'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - (AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_pt_ff <= f_pt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= f_pt_ff;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wtsp_div.sv =====
// ============================================================================
// wtsp_div
// Pipelined restoring divider, one quotient bit per stage, with the quotient
// capped at the normalised coordinate limit.
// ============================================================================
`default_nettype none

module wtsp_div (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [wtsp_pkg::NW-1:0]      num,
   input  wire logic [wtsp_pkg::DW-1:0]      den,
   output logic      [wtsp_pkg::QW-1:0]      quo
);
   import wtsp_pkg::*;

   logic [DW-1:0] rem_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [QW-1:0] nlo_ff [0:QW];
   logic [DW-1:0] d_ff   [0:QW];
   logic          cap_ff [0:QW];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DW'(num[NW-1:QW]);
         nlo_ff[0] <= num[QW-1:0];
         d_ff[0]   <= den;
         cap_ff[0] <= (DW'(num[NW-1:QW]) >= den);
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW:0] t;
      logic        ge;
      always_comb begin
         t  = {rem_ff[k-1], nlo_ff[k-1][QW-k]};
         ge = (t >= {1'b0, d_ff[k-1]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DW'(t - {1'b0, d_ff[k-1]}) : DW'(t);
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
            nlo_ff[k] <= nlo_ff[k-1];
            d_ff[k]   <= d_ff[k-1];
            cap_ff[k] <= cap_ff[k-1];
         end
      end
   end

   assign quo = (cap_ff[QW] || (q_ff[QW] > NDC_CAP)) ? NDC_CAP : q_ff[QW];

endmodule

`default_nettype wire

// ===== sv/wtsp_back.sv =====
// ============================================================================
// wtsp_back
// Execution pipeline: rotation into camera space, near-plane test, focal
// scaling and perspective divide, viewport mapping and saturation.
// ============================================================================
`default_nettype none

module wtsp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wtsp_pkg::cfg_type    cfg,
   input  wire logic                 q_valid,
   input  wire wtsp_pkg::point_type  q_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_visible,
   output logic [31:0]               rsp_screen_x,
   output logic [31:0]               rsp_screen_y
);
   import wtsp_pkg::*;

   logic en;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vo_ff;
   logic signed [PW-1:0] pr_ff [0:8];
   logic signed [PW-1:0] pr_in [0:8];
   logic signed [CW-1:0] c_ff  [0:2];
   logic signed [CW-1:0] c_in  [0:2];
   logic signed [SW-1:0] sum   [0:2];

   logic signed [CW:0]   zsum;
   logic signed [CW-1:0] negz, absx, absy;
   logic [DW-1:0]        magx, magy;
   logic [DW-1:0]        d3_ff;
   logic [PPW-1:0]       xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   side_type             side3_ff, side3_in, side4_ff;
   logic [NW-1:0]        nx4_ff, ny4_ff;
   logic [DW-1:0]        d4_ff;

   logic                 vd_ff   [0:DIV_LAT-1];
   side_type             sd_ff   [0:DIV_LAT-1];
   logic [QW-1:0]        qx, qy;

   logic signed [NDW-1:0] nx_ff, ny_ff;
   logic                  vis5_ff, vis6_ff;
   logic signed [TW-1:0]  tx, ty;
   logic signed [PXW-1:0] px_ff, py_ff;
   logic signed [PXW-1:0] hx, hy;
   logic [OW-1:0]         sx_in, sy_in;
   logic                  vis_o_ff;
   logic [OW-1:0]         sx_o_ff, sy_o_ff;

   assign en  = !vo_ff || !rsp_stall;
   assign pop = en && q_valid;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pr_in[k]   = $signed(cfg.mat[k])   * $signed(q_data.rx);
         pr_in[k+3] = $signed(cfg.mat[k+3]) * $signed(q_data.ry);
         pr_in[k+6] = $signed(cfg.mat[k+6]) * $signed(q_data.rz);
      end
      for (int j = 0; j < 3; j++) begin
         sum[j]  = SW'(pr_ff[j]) + SW'(pr_ff[j+3]) + SW'(pr_ff[j+6]) + SW'(32768);
         c_in[j] = sum[j][SW-1:16];
      end
   end

   always_comb begin
      zsum = (CW+1)'(c_ff[2]) + $signed({{(CW+1-FW){1'b0}}, cfg.near});
      negz = -c_ff[2];
      absx = c_ff[0][CW-1] ? -c_ff[0] : c_ff[0];
      absy = c_ff[1][CW-1] ? -c_ff[1] : c_ff[1];
      magx = absx[DW-1:0];
      magy = absy[DW-1:0];
      side3_in.vis = (zsum[CW] || (zsum == '0)) && (c_ff[2] != '0);
      side3_in.sx  = c_ff[0][CW-1];
      side3_in.sy  = c_ff[1][CW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            pr_ff[k] <= pr_in[k];
         end
         for (int j = 0; j < 3; j++) begin
            c_ff[j] <= c_in[j];
         end
         d3_ff    <= negz[DW-1:0];
         side3_ff <= side3_in;
         xlo_ff   <= PPW'(magx[HW-1:0])  * PPW'(cfg.fx);
         xhi_ff   <= PPW'(magx[DW-1:HW]) * PPW'(cfg.fx);
         ylo_ff   <= PPW'(magy[HW-1:0])  * PPW'(cfg.fy);
         yhi_ff   <= PPW'(magy[DW-1:HW]) * PPW'(cfg.fy);
         nx4_ff   <= (NW'(xhi_ff) << HW) + NW'(xlo_ff) + NW'(d3_ff >> 1);
         ny4_ff   <= (NW'(yhi_ff) << HW) + NW'(ylo_ff) + NW'(d3_ff >> 1);
         d4_ff    <= d3_ff;
         side4_ff <= side3_ff;
         sd_ff[0] <= side4_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   wtsp_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (nx4_ff),
      .den   (d4_ff),
      .quo   (qx)
   );

   wtsp_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (ny4_ff),
      .den   (d4_ff),
      .quo   (qy)
   );

   always_comb begin
      tx = TW'(nx_ff) + ONE_Q16;
      ty = ONE_Q16 - TW'(ny_ff);
      hx = (px_ff + PXW'(1)) >>> 1;
      hy = (py_ff + PXW'(1)) >>> 1;
      if ((&hx[PXW-1:OW-1]) || !(|hx[PXW-1:OW-1])) begin
         sx_in = hx[OW-1:0];
      end else begin
         sx_in = hx[PXW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end
      if ((&hy[PXW-1:OW-1]) || !(|hy[PXW-1:OW-1])) begin
         sy_in = hy[OW-1:0];
      end else begin
         sy_in = hy[PXW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff    <= sd_ff[DIV_LAT-1].sx ? -NDW'(qx) : NDW'(qx);
         ny_ff    <= sd_ff[DIV_LAT-1].sy ? -NDW'(qy) : NDW'(qy);
         vis5_ff  <= sd_ff[DIV_LAT-1].vis;
         px_ff    <= $signed({1'b0, cfg.vw}) * tx;
         py_ff    <= $signed({1'b0, cfg.vh}) * ty;
         vis6_ff  <= vis5_ff;
         vis_o_ff <= vis6_ff;
         sx_o_ff  <= vis6_ff ? sx_in : '0;
         sy_o_ff  <= vis6_ff ? sy_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff    <= q_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         vd_ff[0] <= v4_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         v5_ff <= vd_ff[DIV_LAT-1];
         v6_ff <= v5_ff;
         vo_ff <= v6_ff;
      end
   end

   assign rsp_valid    = vo_ff;
   assign rsp_visible  = vis_o_ff;
   assign rsp_screen_x = sx_o_ff;
   assign rsp_screen_y = sy_o_ff;

endmodule

`default_nettype wire

// ===== sv/world_to_screen_projection.sv =====
// ============================================================================
// world_to_screen_projection
// Perspective projection of world points in Q16.16 to pixel coordinates.
// ============================================================================
// A request carries one world point on req_point_x/y/z and is taken when
// req_valid is high and req_stall is low. Each request yields exactly one
// response on rsp_visible and rsp_screen_x/y, offered with rsp_valid and
// held while rsp_stall is high. Camera position, orientation, near distance,
// focal factors and viewport are written through csr_we, csr_index and
// csr_wdata; the user must write them only while no request is in flight,
// which the block itself does not enforce. One request is taken every cycle
// while the queue is not full. The pipeline has four rotation and scaling
// stages ahead of the 42-stage pipelined divider that forms the perspective
// divide, and three mapping stages behind it.
// A four-entry queue separates intake from the pipeline, so intake carries
// on while a response waits. When rsp_stall is held while rsp_valid is high,
// the whole pipeline holds, the queue fills and req_stall then rises.
// Synchronous reset restores the register defaults (identity orientation)
// and empties the queue and the pipeline; no response is pending after it.
// ============================================================================
`default_nettype none

module world_to_screen_projection (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [31:0]  req_point_x,
   input  wire logic [31:0]  req_point_y,
   input  wire logic [31:0]  req_point_z,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_visible,
   output logic [31:0]       rsp_screen_x,
   output logic [31:0]       rsp_screen_y,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   import wtsp_pkg::*;

   cfg_type   cfg;
   logic      pop;
   logic      q_valid;
   point_type q_data;

   wtsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wtsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .cfg         (cfg),
      .pop         (pop),
      .q_valid     (q_valid),
      .q_data      (q_data)
   );

   wtsp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_visible  (rsp_visible),
      .rsp_screen_x (rsp_screen_x),
      .rsp_screen_y (rsp_screen_y)
   );

endmodule

`default_nettype wire

// ===== test/world_to_screen_projection_tb.sv =====
// ============================================================================
// world_to_screen_projection_tb
// Self-checking bench for the world-to-screen perspective projection.
// ============================================================================
// Points are queued by a stimulus process and offered by a clocked driver
// with random gaps. A clocked monitor applies random stall to the response
// side and compares every response with a projection computed here from the
// current camera registers. Camera settings change between phases, only
// once every pending response has been collected.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module world_to_screen_projection_tb;
   import wtsp_pkg::*;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } bench_point_type;

   typedef struct {
      logic        vis;
      logic [31:0] sx;
      logic [31:0] sy;
   } bench_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_point_x = '0;
   logic [31:0] req_point_y = '0;
   logic [31:0] req_point_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_visible;
   logic [31:0] rsp_screen_x;
   logic [31:0] rsp_screen_y;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   world_to_screen_projection dut (.*);

   always #5 clock = ~clock;

   // Camera registers as the bench believes them to be.
   logic [31:0] cam_x, cam_y, cam_z, viewport;
   logic [63:0] quat;
   logic [30:0] near_d, focal_x, focal_y;

   bench_point_type pending_points[$];
   bench_pixel_type expected_pixels[$];
   int     errors = 0;
   int     idle_cycles = 0;
   bit     send_pause = 0;
   int     hold_off = 0;
   int     gap_left = 0;
   bit     stimulus_done = 0;

   function automatic longint rnd_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // round(mag*f/d) capped at 2^40
   function automatic longint scaled_divide(longint c, logic [30:0] f, longint d);
      logic [127:0] num;
      logic [127:0] q;
      longint       mag;
      longint       r;
      mag = c < 0 ? -c : c;
      num = 128'(mag) * 128'(f) + 128'(d >> 1);
      q = num / 128'(d);
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      r = longint'(q[63:0]);
      return c < 0 ? -r : r;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic bench_pixel_type project_point(bench_point_type p);
      longint w, a, b, c, one, rx, ry, rz, cx, cy, cz, nx, ny, d, vw, vh;
      longint m[3][3];
      bench_pixel_type o;
      w = longint'($signed(quat[15:0]));
      a = longint'($signed(quat[31:16]));
      b = longint'($signed(quat[47:32]));
      c = longint'($signed(quat[63:48]));
      one = longint'(1) << 28;
      m[0][0] = one - 2 * (b * b + c * c);
      m[0][1] = 2 * (a * b - w * c);
      m[0][2] = 2 * (a * c + w * b);
      m[1][0] = 2 * (a * b + w * c);
      m[1][1] = one - 2 * (a * a + c * c);
      m[1][2] = 2 * (b * c - w * a);
      m[2][0] = 2 * (a * c - w * b);
      m[2][1] = 2 * (b * c + w * a);
      m[2][2] = one - 2 * (a * a + b * b);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) m[i][j] = rnd_shr(m[i][j], 12);
      rx = longint'($signed(p.x)) - longint'($signed(cam_x));
      ry = longint'($signed(p.y)) - longint'($signed(cam_y));
      rz = longint'($signed(p.z)) - longint'($signed(cam_z));
      cx = rnd_shr(m[0][0] * rx + m[1][0] * ry + m[2][0] * rz, 16);
      cy = rnd_shr(m[0][1] * rx + m[1][1] * ry + m[2][1] * rz, 16);
      cz = rnd_shr(m[0][2] * rx + m[1][2] * ry + m[2][2] * rz, 16);
      o = '{1'b0, 32'd0, 32'd0};
      if (cz > -longint'(near_d) || cz == 0) return o;
      d = -cz;
      nx = scaled_divide(cx, focal_x, d);
      ny = scaled_divide(cy, focal_y, d);
      vw = longint'(viewport[15:0]);
      vh = longint'(viewport[31:16]);
      o.vis = 1'b1;
      o.sx = clamp32((vw * (65536 + nx) + 1) >>> 1);
      o.sy = clamp32((vh * (65536 - ny) + 1) >>> 1);
      return o;
   endfunction

   // Driver: offers queued points, holds them while stalled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(project_point('{req_point_x, req_point_y,
                                                      req_point_z}));
            void'(pending_points.pop_front());
         end
         if (req_valid && req_stall) begin
            // Payload held.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_points.size() > 0
                      && !send_pause && $urandom_range(0, 9) < 8) begin
            req_valid <= 1'b1;
            req_point_x <= pending_points[0].x;
            req_point_y <= pending_points[0].y;
            req_point_z <= pending_points[0].z;
         end else begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 29) == 0) begin
               gap_left <= $urandom_range(10, 40);
            end
         end
      end
   end

   // Monitor: random stall on the response side and comparison.
   int stall_left = 0;
   always @(posedge clock) begin
      bench_pixel_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected response");
               errors++;
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_visible !== e.vis) begin
                  $error("visible expected %0d actual %0d", e.vis, rsp_visible);
                  errors++;
               end
               if (rsp_screen_x !== e.sx) begin
                  $error("screen_x expected %h actual %h", e.sx, rsp_screen_x);
                  errors++;
               end
               if (rsp_screen_y !== e.sy) begin
                  $error("screen_y expected %h actual %h", e.sy, rsp_screen_y);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < 15) begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any accepted request or response.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_CAM_X:    cam_x = v[31:0];
         REG_CAM_Y:    cam_y = v[31:0];
         REG_CAM_Z:    cam_z = v[31:0];
         REG_QUAT:     quat = v;
         REG_NEAR:     near_d = v[30:0];
         REG_FOCAL_X:  focal_x = v[30:0];
         REG_FOCAL_Y:  focal_y = v[30:0];
         REG_VIEWPORT: viewport = v[31:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      wait (pending_points.size() == 0 && !req_valid);
      wait (expected_pixels.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      pending_points.push_back('{x, y, z});
   endtask

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   function automatic logic [63:0] rnd_quat();
      logic [15:0] h[4];
      if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
      foreach (h[i]) h[i] = 16'($signed($urandom_range(0, 23170)) - 11585);
      return {h[3], h[2], h[1], h[0]};
   endfunction

   task automatic set_camera(int kind);
      case (kind)
         0: begin
            write_reg(REG_CAM_X, 0); write_reg(REG_CAM_Y, 0); write_reg(REG_CAM_Z, 0);
            write_reg(REG_QUAT, 64'd16384); write_reg(REG_NEAR, 6554);
            write_reg(REG_FOCAL_X, 65536); write_reg(REG_FOCAL_Y, 65536);
            write_reg(REG_VIEWPORT, {16'd480, 16'd640});
         end
         1: begin
            write_reg(REG_CAM_X, 64'hFFFF_FFFF_8000_0000);
            write_reg(REG_CAM_Y, 64'h7FFF_FFFF);
            write_reg(REG_CAM_Z, 64'h8000_0000);
            write_reg(REG_QUAT, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(REG_NEAR, 0);
            write_reg(REG_FOCAL_X, 64'h7FFF_FFFF);
            write_reg(REG_FOCAL_Y, 64'h7FFF_FFFF);
            write_reg(REG_VIEWPORT, 64'hFFFF_FFFF);
         end
         2: begin
            write_reg(REG_CAM_X, 0); write_reg(REG_CAM_Y, 0); write_reg(REG_CAM_Z, 0);
            write_reg(REG_QUAT, 64'h8000_7FFF_8000_7FFF);
            write_reg(REG_NEAR, 64'h7FFF_FFFF);
            write_reg(REG_FOCAL_X, 0); write_reg(REG_FOCAL_Y, 1);
            write_reg(REG_VIEWPORT, 0);
         end
         default: begin
            write_reg(REG_CAM_X, $urandom_range(0, 1 << 22) - (1 << 21));
            write_reg(REG_CAM_Y, $urandom_range(0, 1 << 22) - (1 << 21));
            write_reg(REG_CAM_Z, $urandom_range(0, 1 << 22) - (1 << 21));
            write_reg(REG_QUAT, rnd_quat());
            write_reg(REG_NEAR, $urandom_range(0, 3) == 0 ? 31'($urandom())
                                                         : $urandom_range(0, 1 << 17));
            write_reg(REG_FOCAL_X, $urandom_range(0, 1) ? 31'($urandom())
                                                       : $urandom_range(0, 1 << 18));
            write_reg(REG_FOCAL_Y, $urandom_range(0, 1) ? 31'($urandom())
                                                       : $urandom_range(0, 1 << 18));
            write_reg(REG_VIEWPORT, $urandom_range(0, 7) == 0 ? $urandom()
               : {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048))});
         end
      endcase
   endtask

   initial begin
      cam_x = 0; cam_y = 0; cam_z = 0; quat = 64'd16384;
      near_d = 6554; focal_x = 65536; focal_y = 65536; viewport = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: reset settings with a zero viewport, then extremes.
      push_point(0, 0, 32'hFFFF_0000);
      push_point(0, 0, 0);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain();
      set_camera(0);
      push_point(0, 0, 32'hFFFF_E666);                // exactly on the near plane
      push_point(0, 0, 32'hFFFF_E667);
      push_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000);
      push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      drain();
      set_camera(1);
      push_point(0, 0, 0);
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      set_camera(2);
      push_point(0, 0, 32'h8000_0000);
      push_point(32'h1234_5678, 32'h8765_4321, 32'h0000_0001);
      drain();
      write_reg(REG_VIEWPORT, 64'h0100_0100);   // keep a usable viewport

      for (int ph = 0; ph < 15; ph++) begin
         set_camera(3);
         if (ph == 5) begin
            hold_off <= 300;
         end
         for (int k = 0; k < 60; k++)
            push_point(rnd_coord(), rnd_coord(),
                       $urandom_range(0, 3) == 0 ? rnd_coord()
                       : 32'(cam_z - $urandom_range(1, 1 << 22)));
         if (ph == 8) begin
            wait (pending_points.size() < 30);
            send_pause = 1;
            wait (expected_pixels.size() == 0);
            send_pause = 0;
         end
         drain();
      end
      stimulus_done = 1;
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

`default_nettype wire
